// ===== rtl/hrs_pkg.sv =====
package hrs_pkg;

    localparam int unsigned RANK_W  = 10;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned IDX_W   = 11;
    localparam int unsigned OFF_W   = 26;
    localparam int unsigned KIND_W  = 3;

    // larger group sizes are clamped to this
    localparam logic [SIZE_W-1:0] MAX_RANKS = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND     = 3'd0,
        KIND_RECV     = 3'd1,
        KIND_SENDRECV = 3'd2,
        KIND_COPY     = 3'd3,
        KIND_RECV_OUT = 3'd4,
        KIND_INVALID  = 3'd5
    } step_kind_t;

    typedef enum logic {
        REG_GROUP_SIZE  = 1'b0,
        REG_BLOCK_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_INVAL,
        OP_FOLD,
        OP_PHASE,
        OP_COPY,
        OP_UNFOLD
    } step_op_t;

    typedef struct packed {
        logic     load;
        logic     issue;
        step_op_t op;
        logic     last;
    } hrs_cmd_t;

    typedef struct packed {
        logic adv;
        logic invalid;
        logic fold;
        logic odd;
        logic mask_zero;
        logic mask_one;
    } hrs_status_t;

endpackage

// ===== rtl/hrs_ctrl.sv =====
module hrs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid_i,
    input  hrs_pkg::hrs_status_t status_i,
    output logic               s_ready_o,
    output hrs_pkg::hrs_cmd_t  cmd_o
);
    import hrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_INVAL,
        ST_FOLD,
        ST_PHASE,
        ST_COPY,
        ST_UNFOLD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next   = state_reg;
        cmd_o.load   = ready_reg & s_valid_i;
        cmd_o.issue  = 1'b0;
        cmd_o.op     = OP_INVAL;
        cmd_o.last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid_i) state_next = ST_ROUTE;
            end
            ST_ROUTE: begin
                if (status_i.invalid)        state_next = ST_INVAL;
                else if (status_i.fold)      state_next = ST_FOLD;
                else if (status_i.mask_zero) state_next = ST_COPY;
                else                         state_next = ST_PHASE;
            end
            ST_INVAL: begin
                cmd_o.op    = OP_INVAL;
                cmd_o.last  = 1'b1;
                cmd_o.issue = status_i.adv;
                if (status_i.adv) state_next = ST_IDLE;
            end
            ST_FOLD: begin
                cmd_o.op    = OP_FOLD;
                cmd_o.issue = status_i.adv;
                if (status_i.adv) begin
                    if (!status_i.odd)           state_next = ST_UNFOLD;
                    else if (status_i.mask_zero) state_next = ST_COPY;
                    else                         state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                cmd_o.op    = OP_PHASE;
                cmd_o.issue = status_i.adv;
                if (status_i.adv && status_i.mask_one) state_next = ST_COPY;
            end
            ST_COPY: begin
                cmd_o.op    = OP_COPY;
                cmd_o.last  = !status_i.fold;
                cmd_o.issue = status_i.adv;
                if (status_i.adv) state_next = status_i.fold ? ST_UNFOLD : ST_IDLE;
            end
            ST_UNFOLD: begin
                cmd_o.op    = OP_UNFOLD;
                cmd_o.last  = 1'b1;
                cmd_o.issue = status_i.adv;
                if (status_i.adv) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready_o = ready_reg;

endmodule

// ===== rtl/hrs_dp.sv =====
module hrs_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hrs_pkg::hrs_cmd_t             cmd_i,
    input  logic [hrs_pkg::RANK_W-1:0]    s_rank_i,
    input  logic [hrs_pkg::SIZE_W-1:0]    group_size_i,
    input  logic [hrs_pkg::COUNT_W-1:0]   block_count_i,
    input  logic                          m_ready_i,
    output hrs_pkg::hrs_status_t          status_o,
    output logic                          m_valid_o,
    output logic [hrs_pkg::KIND_W-1:0]    m_kind_o,
    output logic [hrs_pkg::RANK_W-1:0]    m_peer_o,
    output logic [hrs_pkg::OFF_W-1:0]     m_soff_o,
    output logic [hrs_pkg::OFF_W-1:0]     m_scnt_o,
    output logic [hrs_pkg::OFF_W-1:0]     m_roff_o,
    output logic [hrs_pkg::OFF_W-1:0]     m_rcnt_o,
    output logic                          m_reduce_o,
    output logic                          m_last_o
);
    import hrs_pkg::*;

    localparam int unsigned PROD_W = COUNT_W + IDX_W;

    // block weight: prefix offset divided by block_count
    function automatic logic [IDX_W-1:0] wgt(input logic [IDX_W-1:0] x,
                                             input logic [RANK_W-1:0] r);
        logic [IDX_W-1:0] m;
        m = (x < {1'b0, r}) ? x : {1'b0, r};
        return x + m;
    endfunction

    // per-request setup
    logic [RANK_W-1:0] rank_reg, newrank_reg, rem_reg, mask_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [IDX_W-1:0]  base_reg, lidx_reg;
    logic              invalid_reg, fold_reg;

    logic [SIZE_W-1:0] size_c, pof2_c;
    logic [RANK_W-1:0] rem_c;
    logic              fold_c;

    always_comb begin
        size_c = (group_size_i > MAX_RANKS) ? MAX_RANKS : group_size_i;
        pof2_c = {{(SIZE_W-1){1'b0}}, 1'b1};
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_c[i]) pof2_c = SIZE_W'(1) << i;
        end
        rem_c  = RANK_W'(size_c - pof2_c);
        fold_c = ({1'b0, s_rank_i} < {rem_c, 1'b0});
    end

    // halving phase recurrence
    logic [RANK_W-1:0] nd, dst;
    logic              lower;
    logic [IDX_W-1:0]  hi, sx, rx, ws, wr, wl;

    always_comb begin
        nd    = newrank_reg ^ mask_reg;
        lower = ((newrank_reg & mask_reg) == '0);
        hi    = base_reg + {1'b0, mask_reg};
        sx    = lower ? hi : base_reg;
        rx    = lower ? base_reg : hi;
        ws    = wgt(sx, rem_reg);
        wr    = wgt(rx, rem_reg);
        wl    = wgt(lidx_reg, rem_reg);
        dst   = (nd < rem_reg) ? {nd[RANK_W-2:0], 1'b1} : nd + rem_reg;
    end

    // stage 1: step fields with weights
    logic              s1_valid_reg, s1_valid_next;
    step_kind_t        s1_kind_reg, s1_kind_next;
    logic [RANK_W-1:0] s1_peer_reg, s1_peer_next;
    logic [IDX_W-1:0]  s1_wso_reg, s1_wso_next, s1_wsc_reg, s1_wsc_next;
    logic [IDX_W-1:0]  s1_wro_reg, s1_wro_next, s1_wrc_reg, s1_wrc_next;
    logic              s1_red_reg, s1_red_next, s1_last_reg, s1_last_next;

    logic adv;
    assign adv = !m_valid_o || m_ready_i;

    always_comb begin
        s1_valid_next = cmd_i.issue;
        s1_kind_next  = KIND_INVALID;
        s1_peer_next  = '0;
        s1_wso_next   = '0;
        s1_wsc_next   = '0;
        s1_wro_next   = '0;
        s1_wrc_next   = '0;
        s1_red_next   = 1'b0;
        s1_last_next  = cmd_i.last;
        case (cmd_i.op)
            OP_INVAL: begin
                s1_kind_next = KIND_INVALID;
            end
            OP_FOLD: begin
                if (rank_reg[0]) begin
                    s1_kind_next = KIND_RECV;
                    s1_peer_next = rank_reg - RANK_W'(1);
                    s1_wrc_next  = size_reg;
                    s1_red_next  = 1'b1;
                end else begin
                    s1_kind_next = KIND_SEND;
                    s1_peer_next = rank_reg + RANK_W'(1);
                    s1_wsc_next  = size_reg;
                end
            end
            OP_PHASE: begin
                s1_kind_next = KIND_SENDRECV;
                s1_peer_next = dst;
                s1_wso_next  = ws;
                s1_wro_next  = wr;
                s1_wsc_next  = lower ? wl - ws : wr - ws;
                s1_wrc_next  = lower ? ws - wr : wl - wr;
                s1_red_next  = 1'b1;
            end
            OP_COPY: begin
                s1_kind_next = KIND_COPY;
                s1_wso_next  = {1'b0, rank_reg};
                s1_wsc_next  = IDX_W'(1);
            end
            OP_UNFOLD: begin
                if (rank_reg[0]) begin
                    s1_kind_next = KIND_SEND;
                    s1_peer_next = rank_reg - RANK_W'(1);
                    s1_wso_next  = {1'b0, rank_reg - RANK_W'(1)};
                    s1_wsc_next  = IDX_W'(1);
                end else begin
                    s1_kind_next = KIND_RECV_OUT;
                    s1_peer_next = rank_reg + RANK_W'(1);
                    s1_wrc_next  = IDX_W'(1);
                end
            end
            default: begin
                s1_kind_next = KIND_INVALID;
            end
        endcase
    end

    // stage 2: scale weights by block_count into the output register
    logic [PROD_W-1:0] p_so, p_sc, p_ro, p_rc;
    assign p_so = PROD_W'(block_count_i) * PROD_W'(s1_wso_reg);
    assign p_sc = PROD_W'(block_count_i) * PROD_W'(s1_wsc_reg);
    assign p_ro = PROD_W'(block_count_i) * PROD_W'(s1_wro_reg);
    assign p_rc = PROD_W'(block_count_i) * PROD_W'(s1_wrc_reg);

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            rank_reg    <= s_rank_i;
            size_reg    <= size_c;
            rem_reg     <= rem_c;
            invalid_reg <= ({1'b0, s_rank_i} >= size_c);
            fold_reg    <= fold_c;
            newrank_reg <= fold_c ? (s_rank_i >> 1) : s_rank_i - rem_c;
            mask_reg    <= pof2_c[SIZE_W-1:1];
            base_reg    <= '0;
            lidx_reg    <= pof2_c;
        end else if (cmd_i.issue && cmd_i.op == OP_PHASE) begin
            base_reg <= rx;
            lidx_reg <= rx + {1'b0, mask_reg};
            mask_reg <= mask_reg >> 1;
        end
        if (adv) begin
            s1_kind_reg <= s1_kind_next;
            s1_peer_reg <= s1_peer_next;
            s1_wso_reg  <= s1_wso_next;
            s1_wsc_reg  <= s1_wsc_next;
            s1_wro_reg  <= s1_wro_next;
            s1_wrc_reg  <= s1_wrc_next;
            s1_red_reg  <= s1_red_next;
            s1_last_reg <= s1_last_next;
            m_kind_o    <= s1_kind_reg;
            m_peer_o    <= s1_peer_reg;
            m_soff_o    <= p_so[OFF_W-1:0];
            m_scnt_o    <= p_sc[OFF_W-1:0];
            m_roff_o    <= p_ro[OFF_W-1:0];
            m_rcnt_o    <= p_rc[OFF_W-1:0];
            m_reduce_o  <= s1_red_reg;
            m_last_o    <= s1_last_reg;
        end
    end

    assign m_valid_o          = m_valid_reg;
    assign status_o.adv       = adv;
    assign status_o.invalid   = invalid_reg;
    assign status_o.fold      = fold_reg;
    assign status_o.odd       = rank_reg[0];
    assign status_o.mask_zero = (mask_reg == '0);
    assign status_o.mask_one  = (mask_reg == RANK_W'(1));

endmodule

// ===== rtl/halving_reduce_scatter_schedule_unit.sv =====
// Channel  Dir  Beat carries                                    Handshake
// s_       in   my_rank (request)                               s_tvalid/s_tready
// m_       out  one schedule step; tlast on the final step      m_tvalid/m_tready
// cfg_     in   group_size (index 0), block_count (index 1)     cfg_we, no wait
//
// A request yields n steps (1 for a bad rank, up to 12): after the accepting
// idle state and a routing state, one step is issued per cycle while the m_
// side does not stall, set by the halving index recurrence. Steps leave
// through a two-deep pipe.
// aresetn is synchronous and active low; config returns to group_size 1,
// block_count 1. A stalled m_ side freezes the pipe and the sequencer together;
// a new request is taken while earlier steps still wait in the output stage.
module halving_reduce_scatter_schedule_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [9:0] my_rank
    output logic         m_tvalid,
    input  logic         m_tready,
    // [9:0] peer_rank, [35:10] send_offset, [61:36] send_count,
    // [87:62] recv_offset, [113:88] recv_count, [119:114] zero
    output logic [119:0] m_tdata,
    output logic [3:0]   m_tuser,   // [2:0] step_kind, [3] do_reduce
    output logic         m_tlast,   // last_step
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata
);
    import hrs_pkg::*;

    // configuration registers
    logic [SIZE_W-1:0]  group_size_reg;
    logic [COUNT_W-1:0] block_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg  <= SIZE_W'(1);
            block_count_reg <= COUNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_GROUP_SIZE:  group_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    hrs_cmd_t    cmd;
    hrs_status_t status;

    logic [KIND_W-1:0] kind;
    logic [RANK_W-1:0] peer;
    logic [OFF_W-1:0]  soff, scnt, roff, rcnt;
    logic              reduce;

    hrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .status_i  (status),
        .s_ready_o (s_tready),
        .cmd_o     (cmd)
    );

    hrs_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .s_rank_i      (s_tdata[RANK_W-1:0]),
        .group_size_i  (group_size_reg),
        .block_count_i (block_count_reg),
        .m_ready_i     (m_tready),
        .status_o      (status),
        .m_valid_o     (m_tvalid),
        .m_kind_o      (kind),
        .m_peer_o      (peer),
        .m_soff_o      (soff),
        .m_scnt_o      (scnt),
        .m_roff_o      (roff),
        .m_rcnt_o      (rcnt),
        .m_reduce_o    (reduce),
        .m_last_o      (m_tlast)
    );

    assign m_tdata = {6'b000000, rcnt, roff, scnt, soff, peer};
    assign m_tuser = {reduce, kind};

    // sequencer leaves idle straight after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken but sequencer still idle");

    // issuing the final step frees the input side
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue && cmd.last |=> s_tready)
        else $error("sequencer not idle after final step");

    // bad-rank beat is a lone, empty, final step
    a_invalid_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == KIND_INVALID |->
            m_tlast && m_tdata == '0 && !m_tuser[3])
        else $error("malformed invalid-rank beat");

    // halving phases always reduce and never close a schedule
    a_phase_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == KIND_SENDRECV |-> m_tuser[3] && !m_tlast)
        else $error("halving phase beat with wrong flags");

endmodule

// ===== bench/halving_reduce_scatter_schedule_unit_test.sv =====
module halving_reduce_scatter_schedule_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;     // [9:0] my_rank
    logic         m_tvalid;
    logic         m_tready;
    // [9:0] peer_rank, [35:10] send_offset, [61:36] send_count,
    // [87:62] recv_offset, [113:88] recv_count, [119:114] zero
    logic [119:0] m_tdata;
    logic [3:0]   m_tuser;     // [2:0] step_kind, [3] do_reduce
    logic         m_tlast;     // last_step
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_wdata;

    always #5 aclk = ~aclk;

    halving_reduce_scatter_schedule_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Schedule steps still owed by the block, oldest first
    // ------------------------------------------------------------------
    typedef struct packed {
        step_kind_t          kind;
        logic [RANK_W-1:0]   peer;
        logic [OFF_W-1:0]    send_off;
        logic [OFF_W-1:0]    send_len;
        logic [OFF_W-1:0]    recv_off;
        logic [OFF_W-1:0]    recv_len;
        logic                reduce;
        logic                last;
    } sched_step_t;

    sched_step_t steps_due[$];

    // shadow of the two registers, as last written
    logic [SIZE_W-1:0]  grp_size_cfg = 11'd1;
    logic [COUNT_W-1:0] blk_cnt_cfg  = 16'd1;

    int unsigned errors     = 0;
    int unsigned beats_seen = 0;
    bit          calm         = 1'b0;  // end of run: no idling either side
    bit          hold_pending = 1'b0;  // ask the receiver for one long hold-off

    // ------------------------------------------------------------------
    // Directed script: config writes and requests. Rows with a typed
    // expectation are single-step schedules readable at a glance
    // (copy-only or bad rank); the rest go through the predictor.
    // ------------------------------------------------------------------
    typedef enum logic { ROW_RANK, ROW_CFG } row_op_t;

    typedef struct packed {
        row_op_t          op;
        cfg_reg_t         sel;
        logic [15:0]      value;   // register data, or the rank
        logic             typed;
        step_kind_t       kind;
        logic [OFF_W-1:0] cnt;     // typed send_count
    } script_row_t;

    localparam int SCRIPT_LEN = 30;

    script_row_t script [SCRIPT_LEN] = '{
        // straight out of reset: one rank, one element
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b1, KIND_COPY,    26'd1},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1,     1'b1, KIND_INVALID, 26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1023,  1'b1, KIND_INVALID, 26'd0},
        '{ROW_CFG,  REG_BLOCK_COUNT, 16'd65535, 1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b1, KIND_COPY,    26'd65535},
        // empty group: every rank is bad
        '{ROW_CFG,  REG_GROUP_SIZE,  16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b1, KIND_INVALID, 26'd0},
        // three ranks: one fold pair plus one straight participant
        '{ROW_CFG,  REG_GROUP_SIZE,  16'd3,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd2,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd3,     1'b1, KIND_INVALID, 26'd0},
        // upper data bits dropped, oversized group clamped to the maximum
        '{ROW_CFG,  REG_GROUP_SIZE,  16'hFFFF,  1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1023,  1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd512,   1'b0, KIND_SEND,    26'd0},
        // longest schedules (fold, nine phases, copy, unfold) and their neighbours
        '{ROW_CFG,  REG_GROUP_SIZE,  16'd1023,  1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1021,  1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1022,  1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1023,  1'b1, KIND_INVALID, 26'd0},
        // zero block count keeps the shape, all sizes zero
        '{ROW_CFG,  REG_BLOCK_COUNT, 16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1022,  1'b0, KIND_SEND,    26'd0},
        '{ROW_CFG,  REG_GROUP_SIZE,  16'd5,     1'b0, KIND_SEND,    26'd0},
        '{ROW_CFG,  REG_BLOCK_COUNT, 16'd7,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd0,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd1,     1'b0, KIND_SEND,    26'd0},
        '{ROW_RANK, REG_GROUP_SIZE,  16'd4,     1'b0, KIND_SEND,    26'd0}
    };

    // ------------------------------------------------------------------
    // Schedule predictor
    // ------------------------------------------------------------------
    // start of participant idx's region: doubled blocks below rem
    function automatic longint unsigned region_base(input longint unsigned idx,
                                                    input longint unsigned rem,
                                                    input longint unsigned cnt);
        return cnt * (idx + ((idx < rem) ? idx : rem));
    endfunction

    function automatic void add_step(input step_kind_t kind, input longint unsigned peer,
                                     input longint unsigned soff, input longint unsigned scnt,
                                     input longint unsigned roff, input longint unsigned rcnt,
                                     input bit reduce, input bit last);
        sched_step_t s;
        s.kind     = kind;
        s.peer     = peer[RANK_W-1:0];
        s.send_off = soff[OFF_W-1:0];
        s.send_len = scnt[OFF_W-1:0];
        s.recv_off = roff[OFF_W-1:0];
        s.recv_len = rcnt[OFF_W-1:0];
        s.reduce   = reduce;
        s.last     = last;
        steps_due.push_back(s);
    endfunction

    function automatic void plan_schedule(input logic [RANK_W-1:0] rank_in);
        longint unsigned rank, size, cnt, pof2, rem, newrank, mask;
        longint unsigned sidx, ridx, lidx, nd, dst, sc, rc;
        bit folding, joins;
        rank    = rank_in;
        size    = (grp_size_cfg > MAX_RANKS) ? MAX_RANKS : grp_size_cfg;
        cnt     = blk_cnt_cfg;
        newrank = 0;
        if (rank >= size) begin
            add_step(KIND_INVALID, 0, 0, 0, 0, 0, 1'b0, 1'b1);
            return;
        end
        pof2 = 1;
        while (pof2 * 2 <= size)
            pof2 = pof2 * 2;
        rem     = size - pof2;
        folding = (rank < 2 * rem);
        joins   = 1'b1;

        // fold: even hands its whole buffer to the odd neighbour
        if (folding) begin
            if (rank[0] == 1'b0) begin
                add_step(KIND_SEND, rank + 1, 0, size * cnt, 0, 0, 1'b0, 1'b0);
                joins = 1'b0;
            end else begin
                add_step(KIND_RECV, rank - 1, 0, 0, 0, size * cnt, 1'b1, 1'b0);
                newrank = rank >> 1;
            end
        end else begin
            newrank = rank - rem;
        end

        if (joins) begin
            mask = pof2 >> 1;
            sidx = 0;
            ridx = 0;
            lidx = pof2;
            while (mask > 0) begin
                nd  = newrank ^ mask;
                dst = (nd < rem) ? nd * 2 + 1 : nd + rem;
                if (newrank < nd) begin
                    sidx = ridx + mask;
                    sc = region_base(lidx, rem, cnt) - region_base(sidx, rem, cnt);
                    rc = region_base(sidx, rem, cnt) - region_base(ridx, rem, cnt);
                end else begin
                    ridx = sidx + mask;
                    sc = region_base(ridx, rem, cnt) - region_base(sidx, rem, cnt);
                    rc = region_base(lidx, rem, cnt) - region_base(ridx, rem, cnt);
                end
                add_step(KIND_SENDRECV, dst, region_base(sidx, rem, cnt), sc,
                         region_base(ridx, rem, cnt), rc, 1'b1, 1'b0);
                sidx = ridx;
                lidx = ridx + mask;
                mask = mask >> 1;
            end
            add_step(KIND_COPY, 0, rank * cnt, cnt, 0, 0, 1'b0, !folding);
        end

        // unfold: odd returns the final block to its even partner
        if (folding) begin
            if (rank[0] == 1'b1)
                add_step(KIND_SEND, rank - 1, (rank - 1) * cnt, cnt, 0, 0, 1'b0, 1'b1);
            else
                add_step(KIND_RECV_OUT, rank + 1, 0, 0, 0, cnt, 1'b0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Error reporting and result checking
    // ------------------------------------------------------------------
    task automatic log_error(input string line);
        $display("%0t ns: %s", $time, line);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            log_error($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                beats_seen, name, got, want));
    endtask

    // Sampled in the active region after the edge, so every value seen here
    // is the one the block presented at that edge.
    always @(posedge aclk) begin : step_check
        sched_step_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (steps_due.size() == 0) begin
                log_error($sformatf("beat %0d arrived with nothing owed, tdata 0x%0h",
                                    beats_seen, m_tdata));
            end else begin
                want = steps_due.pop_front();
                compare_field("step_kind",   m_tuser[2:0],    want.kind);
                compare_field("peer_rank",   m_tdata[9:0],    want.peer);
                compare_field("send_offset", m_tdata[35:10],  want.send_off);
                compare_field("send_count",  m_tdata[61:36],  want.send_len);
                compare_field("recv_offset", m_tdata[87:62],  want.recv_off);
                compare_field("recv_count",  m_tdata[113:88], want.recv_len);
                compare_field("do_reduce",   m_tuser[3],      want.reduce);
                compare_field("last_step",   m_tlast,         want.last);
            end
            beats_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one rank; owed steps are queued at the accepting edge. A gap
    // after the beat drops tvalid, otherwise it stays high into the next one.
    task automatic offer_rank(input logic [RANK_W-1:0] rank, input logic typed,
                              input step_kind_t kind, input logic [OFF_W-1:0] cnt);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rank};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (typed)
            add_step(kind, 0, 0, cnt, 0, 0, 1'b0, 1'b1);
        else
            plan_schedule(rank);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Every request yields a step, so an empty queue means the sequencer is done
    // and every owed beat has left the output pipe.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (steps_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One cycle low after each write so back-to-back writes never
    // lower and raise cfg_we in the same step.
    task automatic write_reg(input cfg_reg_t sel, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
        if (sel == REG_GROUP_SIZE)
            grp_size_cfg = value[SIZE_W-1:0];
        else
            blk_cnt_cfg = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Group sizes biased to powers of two and their neighbours, the
    // extremes, the empty group, oversized values and junk upper bits.
    function automatic logic [15:0] pick_group_size();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(1, 1024));
            3:       return 16'd1 << $urandom_range(0, 10);
            4:       return (16'd1 << $urandom_range(1, 10)) - 16'd1;
            5:       return (16'd1 << $urandom_range(1, 9)) + 16'd1;
            6:       return 16'd0;
            7:       return 16'(1023 + $urandom_range(0, 1));
            8:       return 16'($urandom_range(1025, 2047));
            9:       return {5'($urandom), 11'($urandom_range(1, 64))};
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [15:0] pick_block_count();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly ranks inside the group; now and then the edges and bad ranks.
    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned eff, roll;
        eff  = (grp_size_cfg > MAX_RANKS) ? MAX_RANKS : grp_size_cfg;
        roll = $urandom_range(0, 19);
        if (eff == 0 || roll == 0)
            return RANK_W'($urandom_range(0, 1023));
        if (roll == 1 && eff < 1024)
            return RANK_W'(eff);
        if (roll == 2)
            return RANK_W'(eff - 1);
        return RANK_W'($urandom_range(0, eff - 1));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request so the
    // pipe fills and s_tready drops; steady once the run goes calm.
    // ------------------------------------------------------------------
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!calm && hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned items_left, batch, phase;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'd0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_GROUP_SIZE;
        cfg_wdata <= 16'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed script
        foreach (script[i]) begin
            if (script[i].op == ROW_CFG) begin
                wait_idle();
                write_reg(script[i].sel, script[i].value);
            end else begin
                offer_rank(script[i].value[RANK_W-1:0], script[i].typed,
                           script[i].kind, script[i].cnt);
            end
        end

        // random phases, a fresh setting for each; the tail runs calm
        items_left = 437;
        phase      = 0;
        while (items_left > 0) begin
            wait_idle();
            if (items_left <= 60)
                calm = 1'b1;
            write_reg(REG_GROUP_SIZE, pick_group_size());
            write_reg(REG_BLOCK_COUNT, pick_block_count());
            if (phase == 1)
                hold_pending = 1'b1;
            batch = $urandom_range(20, 45);
            if (batch > items_left)
                batch = items_left;
            repeat (batch)
                offer_rank(pick_rank(), 1'b0, KIND_SEND, '0);
            items_left -= batch;
            phase++;
        end

        s_tvalid <= 1'b0;
        while (steps_due.size() != 0)
            @(posedge aclk);
        // room for any stray beat to show up
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("halving_reduce_scatter_schedule_unit_test: done, clean");
        else
            $display("halving_reduce_scatter_schedule_unit_test: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10ms;
        $display("halving_reduce_scatter_schedule_unit_test: done, errors");
        $finish;
    end

endmodule
